### hdl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared widths, constants, sector codes and the stage-two word type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  // Input and output field widths
  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned KW     = 6;
  // 6000 - c*s fits below 2^13
  localparam int unsigned TermW  = 13;
  // v * term stays at or below 600000
  localparam int unsigned ProdW  = 20;
  // 17 * v * term stays below 2^24
  localparam int unsigned ScaleW = 24;
  // (17 * v * term) / 64 stays below 2^18
  localparam int unsigned QuotW  = 18;
  localparam int unsigned RecipW = 15;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [HueW-1:0]   HueWrap    = 9'd360;
  localparam logic [KW-1:0]     SectorSpan = 6'd60;
  localparam logic [PctW-1:0]   PctMax     = 7'd100;
  localparam logic [TermW-1:0]  FullTerm   = 13'd6000;
  // 255 / 600000 = 17 / (64 * 625)
  localparam logic [4:0]        ScaleMul   = 5'd17;
  localparam int unsigned       ScaleShift = 6;
  localparam logic [9:0]        Divisor    = 10'd625;
  // floor(2^24 / 625): estimate never exceeds the true quotient
  localparam logic [RecipW-1:0] Recip      = 15'd26843;
  localparam int unsigned       RecipShift = 24;

  // Hue sector, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef logic [TermW-1:0] term_t;

  // Stage-two word from the front end
  typedef struct packed {
    sector_e           sector;
    logic [PctW-1:0]   value;
    term_t             term_p;
    term_t             term_q;
    term_t             term_rise;
  } front_t;

  // Hue at the start of a sector
  function automatic logic [HueW-1:0] sector_base(input sector_e sec);
    logic [HueW-1:0] base;
    case (sec)
      SEC_RY:  base = 9'd0;
      SEC_YG:  base = 9'd60;
      SEC_GC:  base = 9'd120;
      SEC_CB:  base = 9'd180;
      SEC_BM:  base = 9'd240;
      SEC_MR:  base = 9'd300;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

### hdl/hsv_front.sv
// ----------------------------------------------------------------------------
// HSV front end
// Stage 1 wraps hue, finds sector and offset, clamps percents.
// Stage 2 forms the three terms 6000 - c*s for p, q and t.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_front
  import hsv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [HueW-1:0] hue_i,
  input  wire logic [PctW-1:0] saturation_i,
  input  wire logic [PctW-1:0] brightness_i,
  output front_t               front_o
);

  logic [HueW-1:0] hue_wrap;
  sector_e         sector_d, sector_q;
  logic [HueW-1:0] offset_full;
  logic [KW-1:0]   k_d, k_q;
  logic [PctW-1:0] sat_d, sat_q;
  logic [PctW-1:0] val_d, val_q;
  logic [KW-1:0]   k_rest;
  term_t           mul_p, mul_q, mul_t;
  front_t          front_d, front_q;

  // Wrap hue once and pick the sector
  always_comb begin
    hue_wrap = (hue_i >= HueWrap) ? hue_i - HueWrap : hue_i;
    if (hue_wrap >= 9'd300) begin
      sector_d = SEC_MR;
    end else if (hue_wrap >= 9'd240) begin
      sector_d = SEC_BM;
    end else if (hue_wrap >= 9'd180) begin
      sector_d = SEC_CB;
    end else if (hue_wrap >= 9'd120) begin
      sector_d = SEC_GC;
    end else if (hue_wrap >= 9'd60) begin
      sector_d = SEC_YG;
    end else begin
      sector_d = SEC_RY;
    end
    offset_full = hue_wrap - sector_base(sector_d);
    k_d   = offset_full[KW-1:0];
    sat_d = (saturation_i > PctMax) ? PctMax : saturation_i;
    val_d = (brightness_i > PctMax) ? PctMax : brightness_i;
  end

  // Stage 1 register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_d;
      k_q      <= k_d;
      sat_q    <= sat_d;
      val_q    <= val_d;
    end
  end

  // Scale saturation by 60, k and 60 - k
  always_comb begin
    k_rest = SectorSpan - k_q;
    mul_p  = TermW'(SectorSpan) * TermW'(sat_q);
    mul_q  = TermW'(k_q) * TermW'(sat_q);
    mul_t  = TermW'(k_rest) * TermW'(sat_q);
    front_d.sector    = sector_q;
    front_d.value     = val_q;
    front_d.term_p    = FullTerm - mul_p;
    front_d.term_q    = FullTerm - mul_q;
    front_d.term_rise = FullTerm - mul_t;
  end

  // Stage 2 register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

`default_nettype wire

### hdl/hsv_level.sv
// ----------------------------------------------------------------------------
// HSV channel level lane
// floor(17 * v * term / 40000) over three register stages, with the
// final one-step quotient correction left combinational for the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_level
  import hsv_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [PctW-1:0]  value_i,
  input  wire term_t            term_i,
  output logic [ChanW-1:0]      level_o
);

  localparam int unsigned EstW = QuotW + RecipW;

  logic [ProdW-1:0]  prod_d, prod_q;
  logic [ScaleW-1:0] scaled;
  logic [QuotW-1:0]  quot_d, quot_q;
  logic [EstW-1:0]   recip_prod;
  logic [ChanW:0]    est_d, est_q;
  logic [QuotW-1:0]  rem_q;
  logic [QuotW-1:0]  back_prod;
  logic [QuotW-1:0]  rem_diff;
  logic [ChanW:0]    level_full;

  // Stage 3: v * term
  assign prod_d = ProdW'(value_i) * ProdW'(term_i);

  // Stage 4: times 17, drop the factor 64
  always_comb begin
    scaled = (ScaleW'(prod_q) << 4) + ScaleW'(prod_q);
    quot_d = scaled[ScaleW-1:ScaleShift];
  end

  // Stage 5: reciprocal estimate of the quotient by 625
  always_comb begin
    recip_prod = EstW'(quot_q) * EstW'(Recip);
    est_d      = recip_prod[EstW-1:RecipShift];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      quot_q <= quot_d;
      est_q  <= est_d;
      rem_q  <= quot_q;
    end
  end

  // Estimate is low by at most one: bump when the remainder overflows
  always_comb begin
    back_prod  = QuotW'(est_q) * QuotW'(Divisor);
    rem_diff   = rem_q - back_prod;
    level_full = (rem_diff >= QuotW'(Divisor)) ? est_q + 1'b1 : est_q;
    level_o    = level_full[ChanW-1:0];
  end

endmodule

`default_nettype wire

### hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Path: an accepted word crosses the front end, the level lanes and the output word register.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, so a stall costs no data.
// Reset: rst_ni clears all valid bits asynchronously; data registers keep.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // hue[8:0], saturation[15:9], brightness[22:16], zero[23]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned Stages = 5;

  logic              adv;
  logic [Stages-1:0] vld_d, vld_q;
  logic              out_vld_d, out_vld_q;
  front_t            front;
  sector_e           sec3_q, sec4_q, sec5_q;
  logic [ChanW-1:0]  lvl_v, lvl_p, lvl_q, lvl_t;
  logic [ChanW-1:0]  red_d, green_d, blue_d;
  logic [ChanW-1:0]  red_q, green_q, blue_q;

  // Advance everything unless the output word is stuck
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  hsv_front u_front (
    .clk_i        (clk_i),
    .en_i         (adv),
    .hue_i        (s_axis_tdata[8:0]),
    .saturation_i (s_axis_tdata[15:9]),
    .brightness_i (s_axis_tdata[22:16]),
    .front_o      (front)
  );

  hsv_level u_lvl_v (
    .clk_i   (clk_i),
    .en_i    (adv),
    .value_i (front.value),
    .term_i  (FullTerm),
    .level_o (lvl_v)
  );

  hsv_level u_lvl_p (
    .clk_i   (clk_i),
    .en_i    (adv),
    .value_i (front.value),
    .term_i  (front.term_p),
    .level_o (lvl_p)
  );

  hsv_level u_lvl_q (
    .clk_i   (clk_i),
    .en_i    (adv),
    .value_i (front.value),
    .term_i  (front.term_q),
    .level_o (lvl_q)
  );

  hsv_level u_lvl_t (
    .clk_i   (clk_i),
    .en_i    (adv),
    .value_i (front.value),
    .term_i  (front.term_rise),
    .level_o (lvl_t)
  );

  // Carry the sector alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec3_q <= front.sector;
      sec4_q <= sec3_q;
      sec5_q <= sec4_q;
    end
  end

  // Route levels to channels by sector
  always_comb begin
    case (sec5_q)
      SEC_RY: begin
        red_d = lvl_v; green_d = lvl_t; blue_d = lvl_p;
      end
      SEC_YG: begin
        red_d = lvl_q; green_d = lvl_v; blue_d = lvl_p;
      end
      SEC_GC: begin
        red_d = lvl_p; green_d = lvl_v; blue_d = lvl_t;
      end
      SEC_CB: begin
        red_d = lvl_p; green_d = lvl_q; blue_d = lvl_v;
      end
      SEC_BM: begin
        red_d = lvl_t; green_d = lvl_p; blue_d = lvl_v;
      end
      default: begin
        red_d = lvl_v; green_d = lvl_p; blue_d = lvl_q;
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  // Shift valid bits with the data
  always_comb begin
    vld_d     = {vld_q[Stages-2:0], s_axis_tvalid};
    out_vld_d = vld_q[Stages-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {blue_q, green_q, red_q};

`ifndef ASSERT_OFF
  // p and q/t levels never exceed the full level and never undercut p
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Stages-1] |-> (lvl_p <= lvl_q && lvl_p <= lvl_t &&
                         lvl_q <= lvl_v && lvl_t <= lvl_v))
    else $error("channel levels out of order");

  // An accepted word enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted word lost at entry");

  // A stall freezes every valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(vld_q) && $stable(out_vld_q)))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

### dv/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives hue, saturation and value words into the converter in bursts, with
// the output side stalling on its own pattern. Each accepted word queues its
// expected color, taken from a typed-in table for simple directed rows or
// from an integer color predictor otherwise. Output words are checked against
// that queue in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_hsv_to_rgb_converter
  import hsv_pkg::*;
();

  // Output word, red in the lowest byte
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgb_t;

  // Input word, hue in the lowest bits
  typedef struct packed {
    logic            pad;
    logic [PctW-1:0] brightness;
    logic [PctW-1:0] saturation;
    logic [HueW-1:0] hue;
  } hsv_t;

  // Directed row: color fixed in the table when known is set
  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] saturation;
    logic [PctW-1:0] brightness;
    logic            known;
    rgb_t            rgb;
  } color_row_t;

  localparam int unsigned ChanFull    = 255;
  localparam int unsigned LevelDiv    = 600000;
  localparam int unsigned RandWords   = 1280;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumRows     = 22;

  localparam color_row_t ColorRows [NumRows] = '{
    '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd60,  7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{9'd180, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{9'd300, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
    // hue wraps past a full turn
    '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd480, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{9'd511, 7'd127, 7'd127, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    // percent above 100 clamps
    '{9'd0,   7'd127, 7'd127, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd0,   7'd0,   7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd90,  7'd101, 7'd101, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    // zero saturation or zero value gives gray at floor(255 * V / 100)
    '{9'd210, 7'd0,   7'd37,  1'b1, '{8'd94,  8'd94,  8'd94 }},
    '{9'd256, 7'd0,   7'd1,   1'b1, '{8'd2,   8'd2,   8'd2  }},
    '{9'd270, 7'd100, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    // sector edges and exact-floor rounding
    '{9'd359, 7'd100, 7'd100, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd59,  7'd100, 7'd100, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd30,  7'd50,  7'd50,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd1,   7'd1,   7'd1,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd0,   7'd64,  7'd100, 1'b0, '{8'd0,   8'd0,   8'd0  }}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  rgb_t        pending_rgb [$];
  rgb_t        got_rgb;
  rgb_t        want_rgb;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned colors_seen = 0;
  int unsigned burst_left;

  hsv_to_rgb_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // One channel level: floor(255 * v * (6000 - c * s) / 600000)
  function automatic logic [ChanW-1:0] level_of(input int unsigned v, input int unsigned s,
                                                input int unsigned c);
    int unsigned num;
    num = ChanFull * v * (FullTerm - c * s);
    return ChanW'(num / LevelDiv);
  endfunction

  // Color the converter should produce for one pixel
  function automatic rgb_t convert_hsv(input logic [HueW-1:0] hue,
                                       input logic [PctW-1:0] sat,
                                       input logic [PctW-1:0] bri);
    int unsigned      h;
    int unsigned      s;
    int unsigned      v;
    int unsigned      k;
    sector_e          sec;
    logic [ChanW-1:0] lv;
    logic [ChanW-1:0] lp;
    logic [ChanW-1:0] lq;
    logic [ChanW-1:0] lt;
    rgb_t             res;
    h = hue;
    if (h >= HueWrap) h = h - HueWrap;
    s = (sat > PctMax) ? PctMax : sat;
    v = (bri > PctMax) ? PctMax : bri;
    sec = sector_e'(h / SectorSpan);
    k = h % SectorSpan;
    lv = level_of(v, s, 0);
    lp = level_of(v, s, SectorSpan);
    lq = level_of(v, s, k);
    lt = level_of(v, s, SectorSpan - k);
    case (sec)
      SEC_RY:  res = '{blue: lp, green: lt, red: lv};
      SEC_YG:  res = '{blue: lp, green: lv, red: lq};
      SEC_GC:  res = '{blue: lt, green: lv, red: lp};
      SEC_CB:  res = '{blue: lv, green: lq, red: lp};
      SEC_BM:  res = '{blue: lv, green: lp, red: lt};
      default: res = '{blue: lq, green: lp, red: lv};
    endcase
    return res;
  endfunction

  // Percent with weight on zero, full scale and the clamped range
  function automatic logic [PctW-1:0] pick_pct();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PctMax;
      2:       return PctW'($urandom_range(PctMax + 1, 127));
      default: return PctW'($urandom_range(0, 127));
    endcase
  endfunction

  // Hue, now and then on a sector edge, possibly one turn up
  function automatic logic [HueW-1:0] pick_hue();
    int unsigned h;
    if ($urandom_range(0, 7) == 0) begin
      h = $urandom_range(0, 5) * SectorSpan + ($urandom_range(0, 1) ? SectorSpan - 1 : 0);
      if (h < 152 && $urandom_range(0, 1)) h = h + HueWrap;
      return HueW'(h);
    end
    return HueW'($urandom_range(0, 511));
  endfunction

  // Offer one word, hold until taken, then queue its color
  task automatic send_pixel(input hsv_t word, input rgb_t color);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_rgb.push_back(color);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      // drop valid for a gap, or keep streaming
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {1'b0, 23'($urandom())};
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_hsv_to_rgb_converter failed");
      $finish;
    end
  end

  // Receiver: stretches of open, light stalls, heavy stalls or a toggling pattern, plus one long hold
  initial begin
    int unsigned mode;
    int unsigned len;
    logic        held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && colors_seen >= HoldAfter) begin
        held = 1'b1;
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= cycle_count[2];
        endcase
      end
    end
  end

  // Check each output word against the oldest queued color
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      colors_seen <= colors_seen + 1;
      got_rgb = m_axis_tdata;
      if (pending_rgb.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got_rgb);
      end else begin
        want_rgb = pending_rgb.pop_front();
        if (got_rgb.red !== want_rgb.red) begin
          mismatch_count++;
          $display("%0t: red expected %0d actual %0d", $time, want_rgb.red, got_rgb.red);
        end
        if (got_rgb.green !== want_rgb.green) begin
          mismatch_count++;
          $display("%0t: green expected %0d actual %0d", $time, want_rgb.green,
                   got_rgb.green);
        end
        if (got_rgb.blue !== want_rgb.blue) begin
          mismatch_count++;
          $display("%0t: blue expected %0d actual %0d", $time, want_rgb.blue, got_rgb.blue);
        end
      end
    end
  end

  // Stimulus
  initial begin
    hsv_t word;
    rgb_t color;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    burst_left     = $urandom_range(1, 24);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (ColorRows[i]) begin
      word  = '{pad: 1'b0, brightness: ColorRows[i].brightness,
                saturation: ColorRows[i].saturation, hue: ColorRows[i].hue};
      color = ColorRows[i].known ? ColorRows[i].rgb
                                 : convert_hsv(word.hue, word.saturation, word.brightness);
      send_pixel(word, color);
    end

    // Random pixels
    repeat (RandWords) begin
      word.pad        = 1'b0;
      word.hue        = pick_hue();
      word.saturation = pick_pct();
      word.brightness = pick_pct();
      send_pixel(word, convert_hsv(word.hue, word.saturation, word.brightness));
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_hsv_to_rgb_converter passed");
    end else begin
      $display("tb_hsv_to_rgb_converter failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
